/* src/kwm_pkg.sv */
// Shared types and constants of the k-way time merge block.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  localparam int unsigned STAMP_W  = 40;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STREAM_W = 3;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned STATUS_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_END    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_RECORD = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_LAST   = 6'b001000,
    S_FETCH  = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  typedef struct packed {
    logic clr;
    logic take;
  } cmp_ctl_t;

endpackage

`default_nettype wire

/* src/kwm_in_if.sv */
// Input channel: record or end marker for one stream.
`timescale 1ns / 1ps
`default_nettype none

interface kwm_in_if
  import kwm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [STREAM_W-1:0] stream;
  logic [STAMP_W-1:0]  stamp;
  logic [DATA_W-1:0]   price_bits;
  logic [DATA_W-1:0]   amount_bits;

  modport source (
    output valid, opcode, stream, stamp, price_bits, amount_bits,
    input  ready
  );

  modport sink (
    input  valid, opcode, stream, stamp, price_bits, amount_bits,
    output ready
  );
endinterface

`default_nettype wire

/* src/kwm_out_if.sv */
// Output channel: merged record, done or reject result.
`timescale 1ns / 1ps
`default_nettype none

interface kwm_out_if
  import kwm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [STREAM_W-1:0] from_stream;
  logic [STAMP_W-1:0]  out_stamp;
  logic [DATA_W-1:0]   out_price_bits;
  logic [DATA_W-1:0]   out_amount_bits;

  modport source (
    output valid, status, from_stream, out_stamp, out_price_bits, out_amount_bits,
    input  ready
  );

  modport sink (
    input  valid, status, from_stream, out_stamp, out_price_bits, out_amount_bits,
    output ready
  );
endinterface

`default_nettype wire

/* src/kwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/kwm_cmp.sv */
// Shared stamp comparator that tracks the earliest head seen in a scan.
`timescale 1ns / 1ps
`default_nettype none

module kwm_cmp
  import kwm_pkg::*;
#(
  parameter int unsigned KEY_W = 40,
  parameter int unsigned IDX_W = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmp_ctl_t         ctl_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [KEY_W-1:0] stamp_i,
  output logic      [IDX_W-1:0] best_idx_o
);

  logic             have_q, have_d;
  logic [KEY_W-1:0] best_q, best_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    have_d = have_q;
    best_d = best_q;
    idx_d  = idx_q;
    if (ctl_i.clr) begin
      have_d = 1'b0;
    end else if (ctl_i.take && (!have_q || (stamp_i < best_q))) begin
      have_d = 1'b1;
      best_d = stamp_i;
      idx_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    idx_q  <= idx_d;
  end

  assign best_idx_o = idx_q;

endmodule

`default_nettype wire

/* src/k_way_time_merge_core.sv */
// Top level of the k-way time merge: sequencer, stream flags, head store and output register.
//
//   channel   | dir | handshake       | payload
//   in_i      | in  | valid / ready   | opcode, stream, stamp, price_bits, amount_bits
//   out_o     | out | valid / ready   | status, from_stream, out_stamp, out_price_bits,
//             |     |                 | out_amount_bits
//   cfg       | in  | cfg_we_i        | cfg_data_i (stream_count)
//
// A record emission passes accept, decide, a read of every head store entry through the one
// comparator, the last compare, the winner fetch and the result. A reject passes accept and
// result, a done result accept, decide and result, an item with no result accept and decide.
// Reset clears the flags and the output valid at once; the head store needs no clearing.
// The result cycle waits while the output register still holds an untaken transaction.
`timescale 1ns / 1ps
`default_nettype none

module k_way_time_merge_core
  import kwm_pkg::*;
#(
  parameter int unsigned STREAMS    = 8,
  parameter int unsigned STAMP_BITS = 40
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  kwm_in_if.sink                  in_i,
  kwm_out_if.source               out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_data_i
);

  localparam int unsigned IdxW    = $clog2(STREAMS);
  localparam int unsigned KeyW    = (STAMP_BITS < STAMP_W) ? STAMP_BITS : STAMP_W;
  localparam int unsigned EntryW  = KeyW + 2 * DATA_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(STREAMS - 1);

  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   count_q;
  logic [STREAMS-1:0]   full_q, full_d;
  logic [STREAMS-1:0]   ended_q, ended_d;
  logic                 done_q, done_d;
  logic [STATUS_W-1:0]  kind_q, kind_d;
  logic [STREAM_W-1:0]  req_stream_q, req_stream_d;
  logic [IdxW-1:0]      cnt_q, cnt_d;
  logic                 rd_go_q;
  logic [IdxW-1:0]      rd_idx_q;

  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [STREAM_W-1:0]  out_from_q, out_from_d;
  logic [STAMP_W-1:0]   out_stamp_q, out_stamp_d;
  logic [DATA_W-1:0]    out_price_q, out_price_d;
  logic [DATA_W-1:0]    out_amount_q, out_amount_d;

  logic [STREAMS-1:0]   used_v;
  logic                 any_head, all_ready, any_active;
  logic                 in_acc, s_used, reject, out_free;
  logic [IdxW-1:0]      s_idx;

  logic                 ram_we, ram_re;
  logic [IdxW-1:0]      ram_raddr;
  logic [EntryW-1:0]    ram_wdata, ram_rdata;
  logic [KeyW-1:0]      rd_stamp;
  logic [DATA_W-1:0]    rd_price, rd_amount;

  cmp_ctl_t             cmp_ctl;
  logic [IdxW-1:0]      best_idx;

  always_comb begin
    for (int i = 0; i < STREAMS; i++) begin
      used_v[i] = (32'(i) < 32'(count_q));
    end
  end

  assign any_head   = |(full_q & used_v);
  assign all_ready  = &(full_q | ended_q | ~used_v);
  assign any_active = |(used_v & ~ended_q);

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign s_idx      = IdxW'(in_i.stream);
  assign s_used     = (32'(in_i.stream) < STREAMS)
                      && ({1'b0, in_i.stream} < count_q);
  assign reject     = (in_i.opcode == OP_RECORD)
                      && (!s_used || full_q[s_idx] || ended_q[s_idx]);
  assign out_free   = !out_valid_q || out_o.ready;

  assign ram_we    = in_acc && (in_i.opcode == OP_RECORD) && !reject;
  assign ram_wdata = {KeyW'(in_i.stamp), in_i.price_bits, in_i.amount_bits};
  assign ram_re    = (state_q == S_SCAN) || (state_q == S_FETCH);
  assign ram_raddr = (state_q == S_SCAN) ? cnt_q : best_idx;
  assign rd_stamp  = ram_rdata[EntryW-1 -: KeyW];
  assign rd_price  = ram_rdata[2*DATA_W-1 -: DATA_W];
  assign rd_amount = ram_rdata[DATA_W-1:0];

  kwm_ram #(
    .WIDTH (EntryW),
    .DEPTH (STREAMS)
  ) u_heads (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cmp_ctl.clr  = (state_q == S_DECIDE);
  assign cmp_ctl.take = rd_go_q && used_v[rd_idx_q] && full_q[rd_idx_q];

  kwm_cmp #(
    .KEY_W (KeyW),
    .IDX_W (IdxW)
  ) u_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (cmp_ctl),
    .idx_i      (rd_idx_q),
    .stamp_i    (rd_stamp),
    .best_idx_o (best_idx)
  );

  always_comb begin
    state_d      = state_q;
    full_d       = full_q;
    ended_d      = ended_q;
    done_d       = done_q;
    kind_d       = kind_q;
    req_stream_d = req_stream_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_from_d   = out_from_q;
    out_stamp_d  = out_stamp_q;
    out_price_d  = out_price_q;
    out_amount_d = out_amount_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_stream_d = in_i.stream;
          if (reject) begin
            kind_d  = ST_REJECT;
            state_d = S_RESULT;
          end else begin
            if (in_i.opcode == OP_RECORD) begin
              full_d[s_idx] = 1'b1;
            end else if (s_used) begin
              ended_d[s_idx] = 1'b1;
            end
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (any_head && all_ready) begin
          kind_d  = ST_RECORD;
          cnt_d   = '0;
          state_d = S_SCAN;
        end else if (!any_head && !any_active && !done_q) begin
          kind_d  = ST_DONE;
          state_d = S_RESULT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_FETCH;
      end
      S_FETCH: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = kind_q;
          out_from_d   = '0;
          out_stamp_d  = '0;
          out_price_d  = '0;
          out_amount_d = '0;
          if (kind_q == ST_RECORD) begin
            out_from_d         = STREAM_W'(best_idx);
            out_stamp_d        = STAMP_W'(rd_stamp);
            out_price_d        = rd_price;
            out_amount_d       = rd_amount;
            full_d[best_idx]   = 1'b0;
          end else if (kind_q == ST_REJECT) begin
            out_from_d = req_stream_q;
          end else begin
            done_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= COUNT_RESET;
      full_q      <= '0;
      ended_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rd_go_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      full_q      <= full_d;
      ended_q     <= ended_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      rd_go_q     <= (state_q == S_SCAN);
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    req_stream_q <= req_stream_d;
    rd_idx_q     <= cnt_q;
    out_status_q <= out_status_d;
    out_from_q   <= out_from_d;
    out_stamp_q  <= out_stamp_d;
    out_price_q  <= out_price_d;
    out_amount_q <= out_amount_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.from_stream     = out_from_q;
  assign out_o.out_stamp       = out_stamp_q;
  assign out_o.out_price_bits  = out_price_q;
  assign out_o.out_amount_bits = out_amount_q;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for the k-way time merge core: directed table, then random merge traffic.
`timescale 1ns / 1ps

module tb_top;
  import kwm_pkg::*;

  localparam int LANES       = 8;
  localparam int CFG_SETTLE  = 24;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_N       = 17;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [DATA_W-1:0]  ONES      = '1;

  typedef struct packed {
    logic                op;
    logic [STREAM_W-1:0] stream;
    logic [STAMP_W-1:0]  stamp;
    logic [DATA_W-1:0]   price;
    logic [DATA_W-1:0]   amount;
  } rec_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [STREAM_W-1:0] from;
    logic [STAMP_W-1:0]  stamp;
    logic [DATA_W-1:0]   price;
    logic [DATA_W-1:0]   amount;
  } rec_out_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [DATA_W-1:0]  price;
    logic [DATA_W-1:0]  amount;
  } head_t;

  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_GIVEN
  } chk_e;

  typedef struct packed {
    chk_e     chk;
    rec_in_t  item;
    rec_out_t want;
  } dir_row_t;

  localparam rec_out_t NO_RES = '0;

  dir_row_t dir_tab [DIR_N] = '{
    '{CHK_NONE,  '{OP_RECORD, 3'd0, 40'd0, 64'd0, 64'd0}, NO_RES},
    '{CHK_GIVEN, '{OP_RECORD, 3'd0, 40'd5, ONES, ONES},
                 '{ST_REJECT, 3'd0, 40'd0, 64'd0, 64'd0}},
    '{CHK_PRED,  '{OP_RECORD, 3'd1, STAMP_MAX, ONES, ONES}, NO_RES},
    '{CHK_PRED,  '{OP_RECORD, 3'd2, 40'd100, 64'h8000_0000_0000_0000, 64'd1}, NO_RES},
    '{CHK_PRED,  '{OP_RECORD, 3'd3, 40'd0, ONES, 64'd0}, NO_RES},
    '{CHK_PRED,  '{OP_RECORD, 3'd4, 40'd1, 64'h0123_4567_89ab_cdef,
                   64'hfedc_ba98_7654_3210}, NO_RES},
    '{CHK_PRED,  '{OP_RECORD, 3'd5, 40'd2, 64'h0000_0000_ffff_ffff,
                   64'hffff_ffff_0000_0000}, NO_RES},
    '{CHK_PRED,  '{OP_END,    3'd6, STAMP_MAX, ONES, ONES}, NO_RES},
    '{CHK_GIVEN, '{OP_RECORD, 3'd6, 40'd7, 64'd7, 64'd7},
                 '{ST_REJECT, 3'd6, 40'd0, 64'd0, 64'd0}},
    '{CHK_GIVEN, '{OP_RECORD, 3'd7, 40'd0, 64'h5555_5555_5555_5555,
                   64'haaaa_aaaa_aaaa_aaaa},
                 '{ST_RECORD, 3'd0, 40'd0, 64'd0, 64'd0}},
    '{CHK_NONE,  '{OP_END,    3'd6, 40'd0, 64'd0, 64'd0}, NO_RES},
    '{CHK_PRED,  '{OP_RECORD, 3'd0, 40'd3, 64'd3, 64'd3}, NO_RES},
    '{CHK_PRED,  '{OP_END,    3'd3, 40'd0, 64'd0, 64'd0}, NO_RES},
    '{CHK_PRED,  '{OP_END,    3'd1, 40'd0, 64'd0, 64'd0}, NO_RES},
    '{CHK_PRED,  '{OP_RECORD, 3'd7, STAMP_MAX, 64'd1, 64'd2}, NO_RES},
    '{CHK_PRED,  '{OP_RECORD, 3'd4, STAMP_MAX, 64'd4, 64'd5}, NO_RES},
    '{CHK_PRED,  '{OP_RECORD, 3'd5, 40'h80_0000_0000, ONES, 64'd0}, NO_RES}
  };

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we_i   = 1'b0;
  logic [COUNT_W-1:0] cfg_data_i = COUNT_RESET;

  kwm_in_if  in_if ();
  kwm_out_if out_if ();

  k_way_time_merge_core #(
    .STREAMS    (LANES),
    .STAMP_BITS (STAMP_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  logic [COUNT_W-1:0] lanes_in_use = COUNT_RESET;
  logic               head_held   [LANES];
  logic               lane_closed [LANES];
  head_t              head_rec    [LANES];
  logic               done_given  = 1'b0;
  rec_out_t           merge_q [$];

  int          mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  logic        quiet        = 1'b0;
  logic        rx_hold_req  = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic lane_used(input int s);
    return s < LANES && s < int'(lanes_in_use);
  endfunction

  task automatic merge_predict(input rec_in_t it, output logic got, output rec_out_t res);
    logic any_head;
    logic all_ready;
    logic any_live;
    int   best;
    got = 1'b0;
    res = NO_RES;
    if (it.op == OP_RECORD) begin
      if (!lane_used(int'(it.stream)) || head_held[it.stream] || lane_closed[it.stream]) begin
        got        = 1'b1;
        res.status = ST_REJECT;
        res.from   = it.stream;
        return;
      end
      head_held[it.stream] = 1'b1;
      head_rec[it.stream]  = '{it.stamp, it.price, it.amount};
    end else if (lane_used(int'(it.stream))) begin
      lane_closed[it.stream] = 1'b1;
    end
    any_head  = 1'b0;
    all_ready = 1'b1;
    any_live  = 1'b0;
    best      = 0;
    for (int i = 0; i < LANES; i++) begin
      if (lane_used(i)) begin
        if (!lane_closed[i]) any_live = 1'b1;
        if (head_held[i]) begin
          if (!any_head || head_rec[i].stamp < head_rec[best].stamp) best = i;
          any_head = 1'b1;
        end else if (!lane_closed[i]) begin
          all_ready = 1'b0;
        end
      end
    end
    if (any_head && all_ready) begin
      head_held[best] = 1'b0;
      got = 1'b1;
      res = '{ST_RECORD, STREAM_W'(best), head_rec[best].stamp, head_rec[best].price,
              head_rec[best].amount};
    end else if (!any_head && !any_live && !done_given) begin
      done_given = 1'b1;
      got        = 1'b1;
      res.status = ST_DONE;
    end
  endtask

  function automatic rec_in_t rand_payload();
    rec_in_t     it;
    logic [63:0] w;
    w         = {$urandom, $urandom};
    it.op     = 1'($urandom_range(0, 1));
    it.stream = STREAM_W'($urandom_range(0, LANES - 1));
    it.stamp  = ($urandom_range(0, 1) == 0) ? STAMP_W'($urandom_range(0, 15)) : w[STAMP_W-1:0];
    it.price  = {$urandom, $urandom};
    it.amount = {$urandom, $urandom};
    return it;
  endfunction

  // refill an empty live lane most of the time; otherwise noise that never closes a live lane
  function automatic rec_in_t pick_item();
    rec_in_t it;
    int      open_l [$];
    it = rand_payload();
    for (int i = 0; i < LANES; i++) begin
      if (lane_used(i) && !lane_closed[i] && !head_held[i]) open_l.insert(open_l.size(), i);
    end
    if (open_l.size() != 0 && $urandom_range(0, 99) < 85) begin
      it.op     = OP_RECORD;
      it.stream = STREAM_W'(open_l[$urandom_range(0, open_l.size() - 1)]);
    end else if (it.op == OP_END && lane_used(int'(it.stream)) && !lane_closed[it.stream]) begin
      it.op = OP_RECORD;
    end
    return it;
  endfunction

  task automatic push_item(input rec_in_t it, input chk_e chk, input rec_out_t given);
    logic     got;
    rec_out_t res;
    in_if.valid       <= 1'b1;
    in_if.opcode      <= it.op;
    in_if.stream      <= it.stream;
    in_if.stamp       <= it.stamp;
    in_if.price_bits  <= it.price;
    in_if.amount_bits <= it.amount;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    merge_predict(it, got, res);
    case (chk)
      CHK_PRED: begin
        if (got) merge_q.insert(merge_q.size(), res);
      end
      CHK_GIVEN: begin
        merge_q.insert(merge_q.size(), given);
      end
      default: begin
      end
    endcase
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (merge_q.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
  endtask

  task automatic set_lanes(input logic [COUNT_W-1:0] v);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    lanes_in_use  = v;
  endtask

  task automatic run_phase(input int n, input logic pause_mid);
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (merge_q.size() != 0) @(posedge clk_i);
      end
      push_item(pick_item(), CHK_PRED, NO_RES);
    end
  endtask

  task automatic cmp_field(input string name, input logic [DATA_W-1:0] want,
                           input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    rec_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (merge_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got status %0d stream %0d",
                 $time, out_if.status, out_if.from_stream);
        mismatch_cnt++;
      end else begin
        want = merge_q[0];
        merge_q.delete(0);
        cmp_field("status", 64'(want.status), 64'(out_if.status));
        cmp_field("from_stream", 64'(want.from), 64'(out_if.from_stream));
        cmp_field("out_stamp", 64'(want.stamp), 64'(out_if.out_stamp));
        cmp_field("out_price_bits", want.price, out_if.out_price_bits);
        cmp_field("out_amount_bits", want.amount, out_if.out_amount_bits);
      end
    end
  end

  initial begin : receiver
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    rec_in_t it;
    int      live_l [$];
    in_if.valid       <= 1'b0;
    in_if.opcode      <= OP_RECORD;
    in_if.stream      <= '0;
    in_if.stamp       <= '0;
    in_if.price_bits  <= '0;
    in_if.amount_bits <= '0;
    for (int i = 0; i < LANES; i++) begin
      head_held[i]   = 1'b0;
      lane_closed[i] = 1'b0;
      head_rec[i]    = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_N; r++) push_item(dir_tab[r].item, dir_tab[r].chk, dir_tab[r].want);

    run_phase(110, 1'b0);
    set_lanes(4'd1);
    run_phase(60, 1'b0);
    set_lanes(4'd4);
    run_phase(80, 1'b1);
    set_lanes(4'd15);
    rx_hold_req = 1'b1;
    run_phase(100, 1'b0);
    set_lanes(4'd2);
    run_phase(60, 1'b0);

    quiet = 1'b1;
    set_lanes(4'd8);
    run_phase(40, 1'b0);
    // close the live lanes while still refilling
    do begin
      live_l.delete();
      for (int i = 0; i < LANES; i++) begin
        if (lane_used(i) && !lane_closed[i]) live_l.insert(live_l.size(), i);
      end
      if (live_l.size() != 0) begin
        it = pick_item();
        if ($urandom_range(0, 2) == 0) begin
          it.op     = OP_END;
          it.stream = STREAM_W'(live_l[$urandom_range(0, live_l.size() - 1)]);
        end
        push_item(it, CHK_PRED, NO_RES);
      end
    end while (live_l.size() != 0);
    // drain the remaining heads, then the done transaction
    while (!done_given) begin
      it    = rand_payload();
      it.op = OP_END;
      push_item(it, CHK_PRED, NO_RES);
    end
    set_lanes(4'd0);
    run_phase(8, 1'b0);

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (merge_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && merge_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
src/kwm_pkg.sv
src/kwm_in_if.sv
src/kwm_out_if.sv
src/kwm_ram.sv
src/kwm_cmp.sv
src/k_way_time_merge_core.sv
tb/tb_top.sv
